FILE: rtl/sorted_keyed_table_top_defines.svh
// Assertion macros for the sorted keyed table.
// Used by sorted_keyed_table_top; expects clk and rst in scope.
`ifndef SORTED_KEYED_TABLE_TOP_DEFINES_SVH
`define SORTED_KEYED_TABLE_TOP_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define SKT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_keyed_table check failed");

// Antecedent implies consequent in the next cycle.
`define SKT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_keyed_table check failed");

`endif

FILE: rtl/skt_pkg.sv
// Package for the sorted keyed table: sizes, codes, entry type, name cleanup.
// No dependencies.
package skt_pkg;

  localparam int DEPTH = 16;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    F_INSERT    = 3'd0,
    F_DELETE    = 3'd1,
    F_CLEAR     = 3'd2,
    F_MODIFY    = 3'd3,
    F_FIND_ID   = 3'd4,
    F_FIND_NAME = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_REJECT   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT
  } state_t;

  typedef struct packed {
    logic [30:0] id;
    logic [63:0] head;
    logic [7:0]  tail;
  } entry_t;

  // Zero every byte after the first zero byte of the head.
  function automatic logic [63:0] norm_head(input logic [63:0] h);
    logic [63:0] r;
    logic        alive;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (h[8*i +: 8] == 8'd0) alive = 1'b0;
      if (alive) r[8*i +: 8] = h[8*i +: 8];
    end
    return r;
  endfunction

  // Ninth byte survives only if all eight head bytes are nonzero.
  function automatic logic [7:0] norm_tail(input logic [63:0] h, input logic [7:0] t);
    logic alive;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (h[8*i +: 8] == 8'd0) alive = 1'b0;
    end
    return alive ? t : 8'd0;
  endfunction

endpackage

FILE: rtl/sorted_keyed_table_top.sv
// Sorted keyed table: ordered id/name store in one synchronous memory.
// Depends on skt_pkg and sorted_keyed_table_top_defines.svh.
//
// Usage:
// - Request channel (in_valid/in_ready) carries func, key_id, new_id and the
//   name; one request is taken at a time, in_ready is high only when idle.
// - Result channel (out_valid/out_ready) is one output register; all
//   requests but codes six and seven give a result with last set; find by
//   name with hits gives one per hit in table order, last on the final one.
// - Work with n entries stored: a scan reads each entry and then checks
//   it (the memory read is registered), then a shift moves one entry at
//   a time, reading it and then writing it. Insert scans all n entries,
//   delete stops at the match, modify runs a delete and then an insert,
//   and clear needs no scan.
// - A stalled receiver holds the result register; a find scan pauses on
//   the next hit until the register frees, other requests wait in the
//   final state.
// - Synchronous reset empties the table (count to zero); memory contents
//   are not cleared since entries beyond the count are never read.
// - Codes six and seven are taken and dropped with no result.
`include "sorted_keyed_table_top_defines.svh"

module sorted_keyed_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [30:0] key_id,
  input  logic [30:0] new_id,
  input  logic [63:0] name_head,
  input  logic [7:0]  name_tail,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [30:0] out_id,
  output logic [63:0] out_name_head,
  output logic [7:0]  out_name_tail,
  output logic        last
);

  localparam int CW = skt_pkg::CW;
  localparam int AW = skt_pkg::AW;

  skt_pkg::entry_t mem [skt_pkg::DEPTH];
  skt_pkg::entry_t rdata;

  skt_pkg::state_t  state, state_next;
  skt_pkg::func_t   op, op_next;
  logic             ins, ins_next;
  logic [30:0]      key, key_next, nid, nid_next;
  logic [63:0]      head, head_next;
  logic [7:0]       tail, tail_next;
  logic [CW-1:0]    idx, idx_next, pos, pos_next, count, count_next;
  logic             posfound, posfound_next, found, found_next, dup, dup_next;
  skt_pkg::status_t res_status, res_status_next;
  skt_pkg::entry_t  res, res_next;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  skt_pkg::entry_t mem_wdata;
  logic            push, out_free, hit;
  logic [CW-1:0]   idx_inc, idx_dec;

  assign in_ready = (state == skt_pkg::S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= skt_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    op         <= op_next;
    ins        <= ins_next;
    key        <= key_next;
    nid        <= nid_next;
    head       <= head_next;
    tail       <= tail_next;
    idx        <= idx_next;
    pos        <= pos_next;
    posfound   <= posfound_next;
    found      <= found_next;
    dup        <= dup_next;
    res_status <= res_status_next;
    res        <= res_next;
    if (push) begin
      status        <= res_status;
      out_id        <= res.id;
      out_name_head <= res.head;
      out_name_tail <= res.tail;
      last          <= (state == skt_pkg::S_PUT);
    end
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    ins_next        = ins;
    key_next        = key;
    nid_next        = nid;
    head_next       = head;
    tail_next       = tail;
    idx_next        = idx;
    pos_next        = pos;
    posfound_next   = posfound;
    found_next      = found;
    dup_next        = dup;
    count_next      = count;
    res_status_next = res_status;
    res_next        = res;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_waddr       = idx[AW-1:0];
    mem_raddr       = idx[AW-1:0];
    mem_wdata       = '{id: nid, head: head, tail: tail};
    push            = 1'b0;
    hit             = 1'b0;

    case (state)
      skt_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next         = skt_pkg::func_t'(func);
          ins_next        = (func == skt_pkg::F_INSERT);
          key_next        = key_id;
          nid_next        = new_id;
          head_next       = skt_pkg::norm_head(name_head);
          tail_next       = skt_pkg::norm_tail(name_head, name_tail);
          idx_next        = '0;
          found_next      = 1'b0;
          dup_next        = 1'b0;
          posfound_next   = 1'b0;
          res_status_next = skt_pkg::ST_NOTFOUND;
          res_next        = '0;
          case (func) inside
            skt_pkg::F_CLEAR: begin
              count_next      = '0;
              res_status_next = skt_pkg::ST_OK;
              state_next      = skt_pkg::S_PUT;
            end
            skt_pkg::F_INSERT, skt_pkg::F_DELETE, skt_pkg::F_MODIFY,
            skt_pkg::F_FIND_ID, skt_pkg::F_FIND_NAME: begin
              state_next = skt_pkg::S_SCAN_RD;
            end
            default: state_next = skt_pkg::S_IDLE;
          endcase
        end
      end

      skt_pkg::S_SCAN_RD: begin
        if (idx == count) begin
          state_next = skt_pkg::S_DECIDE;
        end else begin
          mem_re     = 1'b1;
          state_next = skt_pkg::S_SCAN_CHK;
        end
      end

      skt_pkg::S_SCAN_CHK: begin
        if (op == skt_pkg::F_FIND_ID || op == skt_pkg::F_FIND_NAME) begin
          hit = (op == skt_pkg::F_FIND_ID) ? (rdata.id == key)
                : (rdata.head == head && rdata.tail == tail);
          if (!hit) begin
            idx_next   = idx_inc;
            state_next = skt_pkg::S_SCAN_RD;
          end else if (!found || out_free) begin
            // previous hit goes out with last low; this one is held
            push            = found;
            res_status_next = skt_pkg::ST_OK;
            res_next        = rdata;
            found_next      = 1'b1;
            idx_next        = idx_inc;
            state_next      = skt_pkg::S_SCAN_RD;
          end
        end else if (ins) begin
          if (rdata.id == nid) dup_next = 1'b1;
          if (!posfound && rdata.id > nid) begin
            pos_next      = idx;
            posfound_next = 1'b1;
          end
          idx_next   = idx_inc;
          state_next = skt_pkg::S_SCAN_RD;
        end else if (rdata.id == key) begin
          pos_next   = idx;
          found_next = 1'b1;
          state_next = skt_pkg::S_DECIDE;
        end else begin
          idx_next   = idx_inc;
          state_next = skt_pkg::S_SCAN_RD;
        end
      end

      skt_pkg::S_DECIDE: begin
        if (op == skt_pkg::F_FIND_ID || op == skt_pkg::F_FIND_NAME) begin
          state_next = skt_pkg::S_PUT;
        end else if (ins) begin
          if (nid == 31'd0 || dup) begin
            res_status_next = skt_pkg::ST_REJECT;
            state_next      = skt_pkg::S_PUT;
          end else if (count == CW'(skt_pkg::DEPTH)) begin
            res_status_next = skt_pkg::ST_FULL;
            state_next      = skt_pkg::S_PUT;
          end else begin
            if (!posfound) pos_next = count;
            idx_next   = count;
            state_next = skt_pkg::S_SHIFT_RD;
          end
        end else if (!found) begin
          res_status_next = skt_pkg::ST_NOTFOUND;
          state_next      = skt_pkg::S_PUT;
        end else begin
          idx_next   = pos;
          state_next = skt_pkg::S_SHIFT_RD;
        end
      end

      skt_pkg::S_SHIFT_RD: begin
        if (ins) begin
          if (idx == pos) begin
            mem_we          = 1'b1;
            count_next      = count + CW'(1);
            res_status_next = skt_pkg::ST_OK;
            state_next      = skt_pkg::S_PUT;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = idx_dec[AW-1:0];
            state_next = skt_pkg::S_SHIFT_WR;
          end
        end else if (idx_inc >= count) begin
          count_next = count - CW'(1);
          if (op == skt_pkg::F_MODIFY) begin
            // old entry gone; rerun the scan as an insert
            ins_next      = 1'b1;
            idx_next      = '0;
            dup_next      = 1'b0;
            posfound_next = 1'b0;
            state_next    = skt_pkg::S_SCAN_RD;
          end else begin
            res_status_next = skt_pkg::ST_OK;
            state_next      = skt_pkg::S_PUT;
          end
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = idx_inc[AW-1:0];
          state_next = skt_pkg::S_SHIFT_WR;
        end
      end

      skt_pkg::S_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_wdata  = rdata;
        idx_next   = ins ? idx_dec : idx_inc;
        state_next = skt_pkg::S_SHIFT_RD;
      end

      skt_pkg::S_PUT: begin
        if (out_free) begin
          push       = 1'b1;
          state_next = skt_pkg::S_IDLE;
        end
      end

      default: state_next = skt_pkg::S_IDLE;
    endcase
  end

  `SKT_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(skt_pkg::DEPTH))
  `SKT_ASSERT_NOW(a_write_in_range, mem_we, {1'b0, mem_waddr} <= count)
  `SKT_ASSERT_NEXT(a_clear_empties, in_valid && in_ready && func == skt_pkg::F_CLEAR, count == '0)

endmodule
